// File: design/mcec_pkg.sv
// Shared types, constants and helper functions for the Monte Carlo call accumulator.
`default_nettype none

package mcec_pkg;

   localparam int COUNT_W   = 24;
   localparam int CNT_W     = COUNT_W + 1;
   localparam int PATHS_W   = 25;
   localparam int MUL_A_W   = 35;
   localparam int MUL_B_W   = 33;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HORNER_N_W = 4;

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1) << COUNT_W;
   localparam logic [HORNER_N_W-1:0] HORNER_TERMS = HORNER_N_W'(10);
   localparam logic [HORNER_N_W-1:0] HORNER_LAST  = HORNER_N_W'(1);

   localparam logic [MUL_B_W-1:0] LOG2E_Q29 = MUL_B_W'(774541002);
   localparam logic [MUL_B_W-1:0] LN2_Q30   = MUL_B_W'(744261118);
   localparam logic signed [39:0] EXP_LIMIT = 40'sd6442450944;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
   localparam logic [30:0] DISCOUNT_RESET = 31'h4000_0000;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPOT_PRICE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRIKE     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOG_DRIFT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOG_VOL    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DISCOUNT   = 3'd4;

   typedef struct packed {
      logic [31:0]        spot_price;
      logic [31:0]        strike;
      logic signed [31:0] log_drift;
      logic [30:0]        log_vol;
      logic [30:0]        discount;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] z;
      logic               mirror;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [31:0]        price;
      logic [PATHS_W-1:0] paths;
      logic               overflow;
   } res_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_X_MUL,
      ST_X_ADD,
      ST_Y_MUL,
      ST_T_MUL,
      ST_T_CAP,
      ST_H_MUL,
      ST_H_RCP,
      ST_H_UPD,
      ST_S_MUL,
      ST_S_SHF,
      ST_PAY,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_P_HI,
      ST_P_LO,
      ST_EMIT
   } state_type;

   // Exact reciprocal ceil(2^(31+l)/n) with 2^l >= n, valid for dividends below 2^31.
   function automatic logic [31:0] horner_recip(input logic [HORNER_N_W-1:0] n);
      logic [31:0] r;
      begin
         case (n)
            4'd3, 4'd6: r = 32'd2863311531;
            4'd5, 4'd10: r = 32'd3435973837;
            4'd7:  r = 32'd2454267027;
            4'd9:  r = 32'd3817748708;
            default: r = 32'd2147483648;
         endcase
         return r;
      end
   endfunction

   function automatic logic [5:0] horner_shift(input logic [HORNER_N_W-1:0] n);
      logic [5:0] s;
      begin
         case (n)
            4'd2:                      s = 6'd32;
            4'd3, 4'd4:                s = 6'd33;
            4'd5, 4'd6, 4'd7, 4'd8:    s = 6'd34;
            4'd9, 4'd10:               s = 6'd35;
            default:                   s = 6'd31;
         endcase
         return s;
      end
   endfunction

endpackage

`default_nettype wire

// File: design/mc_european_call_accumulator.sv
// Top level of the Monte Carlo European call accumulator.
//
// Each req_ transaction carries one normal sample z (Q4.28) in req_tdata, the
// antithetic flag in req_tuser and the end-of-run mark in req_tlast. The block
// prices the path at z, and also at -z when the flag is set, on one shared
// multiplier under a sequencer; the payoffs add into a saturating 64-bit sum.
// A path runs through the sequencer states in order, its ten Horner steps each
// a multiply, a reciprocal multiply and an update; a new item is accepted only
// after the path, or both paths with the antithetic flag, has been accumulated.
// On the last item a bit-serial divider forms the mean in 64 steps, two more
// multiplies apply the discount, and the result is offered to the output
// register. req_tready is high only while idle.
// The result waits in the rsp_ register while the receiver stalls; new items
// are still taken, and a following result waits until the register drains.
// The csr_ port writes a register at every edge with csr_we high; write only
// while idle. Reset clears the run state and returns the registers to their
// reset values (discount to 1.0); no result is pending afterwards.
`default_nettype none

module mc_european_call_accumulator
   import mcec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,  // z
   input  wire logic                  req_tuser,  // mirror
   input  wire logic                  req_tlast,  // last
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,  // price, paths, zero fill
   output logic                       rsp_tuser,  // overflow
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     rsp_valid_ff, rsp_valid_in;
   res_type  rsp_data_ff, rsp_data_in;
   item_type in_item;
   logic     res_valid;
   logic     res_ready;
   res_type  res;

   assign in_item.z      = $signed(req_tdata);
   assign in_item.mirror = req_tuser;
   assign in_item.last   = req_tlast;

   mcec_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SPOT_PRICE: cfg_in.spot_price = csr_wdata;
            CSR_STRIKE:     cfg_in.strike     = csr_wdata;
            CSR_LOG_DRIFT:  cfg_in.log_drift  = $signed(csr_wdata);
            CSR_LOG_VOL:    cfg_in.log_vol    = csr_wdata[30:0];
            CSR_DISCOUNT:   cfg_in.discount   = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spot_price <= '0;
         cfg_ff.strike     <= '0;
         cfg_ff.log_drift  <= '0;
         cfg_ff.log_vol    <= '0;
         cfg_ff.discount   <= DISCOUNT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.paths, rsp_data_ff.price};
   assign rsp_tuser  = rsp_data_ff.overflow;

endmodule

`default_nettype wire

// File: design/mcec_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module mcec_mul
   import mcec_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic signed [MUL_A_W-1:0] a,
   input  wire logic signed [MUL_B_W-1:0] b,
   output logic signed [MUL_P_W-1:0]      p
);

   logic signed [MUL_P_W-1:0] p_ff;
   logic signed [MUL_P_W-1:0] p_in;

   assign p_in = MUL_P_W'(a) * MUL_P_W'(b);
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mcec_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mcec_div
   import mcec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  busy,
   output logic [DIV_W-1:0]      quot
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     divisor_ff, divisor_in;
   logic [CNT_W:0]       rem_sh;
   logic [CNT_W+1:0]     diff;

   assign rem_sh = {rem_ff, quot_ff[DIV_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (diff[CNT_W+1]) begin
            rem_in  = rem_sh[CNT_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in  = diff[CNT_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// File: design/mcec_engine.sv
// Sequencer and datapath: prices paths, sums payoffs, emits discounted mean.
`default_nettype none

module mcec_engine
   import mcec_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          res_valid,
   input  wire logic     res_ready,
   output res_type       res
);

   state_type state_ff, state_in;

   logic signed [32:0]    zz_ff, zz_in;
   logic                  side_ff, side_in;
   logic                  mirror_ff, mirror_in;
   logic                  last_ff, last_in;
   logic signed [33:0]    x_ff, x_in;
   logic signed [6:0]     k_ff, k_in;
   logic [29:0]           t_ff, t_in;
   logic [31:0]           e_ff, e_in;
   logic [HORNER_N_W-1:0] n_ff, n_in;
   logic [31:0]           s_ff, s_in;
   logic [31:0]           pay_ff, pay_in;
   logic [63:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [62:0]           hi_ff, hi_in;

   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      div_start;
   logic                      div_busy;
   logic [DIV_W-1:0]          div_quot;

   logic signed [39:0] x_sum;
   logic [62:0]        rcp_prod;
   logic [62:0]        qd_wide;
   logic [6:0]         amt_full;
   logic [67:0]        shifted;
   logic [64:0]        sum_add;
   logic [CNT_W:0]     cnt_add;
   logic [33:0]        price_sum;
   logic               price_sat;

   mcec_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   mcec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quot     (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (in_valid) state_in = ST_X_MUL;
         ST_X_MUL:    state_in = ST_X_ADD;
         ST_X_ADD:    state_in = ST_Y_MUL;
         ST_Y_MUL:    state_in = ST_T_MUL;
         ST_T_MUL:    state_in = ST_T_CAP;
         ST_T_CAP:    state_in = ST_H_MUL;
         ST_H_MUL:    state_in = ST_H_RCP;
         ST_H_RCP:    state_in = ST_H_UPD;
         ST_H_UPD:    state_in = (n_ff == HORNER_LAST) ? ST_S_MUL : ST_H_MUL;
         ST_S_MUL:    state_in = ST_S_SHF;
         ST_S_SHF:    state_in = ST_PAY;
         ST_PAY:      state_in = ST_ACC;
         ST_ACC: begin
            priority if (mirror_ff && !side_ff) state_in = ST_X_MUL;
            else if (last_ff)                   state_in = ST_DIV_GO;
            else                                state_in = ST_IDLE;
         end
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (!div_busy) state_in = ST_P_HI;
         ST_P_HI:     state_in = ST_P_LO;
         ST_P_LO:     state_in = ST_EMIT;
         ST_EMIT:     if (res_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = 1'b0;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: in_ready = 1'b1;
         ST_X_MUL: begin
            mul_en = 1'b1;
            mul_a  = {{2{zz_ff[32]}}, zz_ff};
            mul_b  = {2'b00, cfg.log_vol};
         end
         ST_Y_MUL: begin
            mul_en = 1'b1;
            mul_a  = {x_ff[33], x_ff};
            mul_b  = LOG2E_Q29;
         end
         ST_T_MUL: begin
            mul_en = 1'b1;
            mul_a  = {7'd0, mul_p[56:29]};
            mul_b  = LN2_Q30;
         end
         ST_H_MUL: begin
            mul_en = 1'b1;
            mul_a  = {3'd0, e_ff};
            mul_b  = {3'd0, t_ff};
         end
         ST_H_RCP: begin
            mul_en = 1'b1;
            mul_a  = {4'd0, mul_p[60:30]};
            mul_b  = {1'b0, horner_recip(n_ff)};
         end
         ST_S_MUL: begin
            mul_en = 1'b1;
            mul_a  = {3'd0, cfg.spot_price};
            mul_b  = {1'b0, e_ff};
         end
         ST_DIV_GO: div_start = 1'b1;
         ST_P_HI: begin
            mul_en = 1'b1;
            mul_a  = {3'd0, div_quot[63:32]};
            mul_b  = {2'b00, cfg.discount};
         end
         ST_P_LO: begin
            mul_en = 1'b1;
            mul_a  = {3'd0, div_quot[31:0]};
            mul_b  = {2'b00, cfg.discount};
         end
         ST_EMIT: res_valid = 1'b1;
         default: ;
      endcase
   end

   assign x_sum     = $signed(mul_p[67:28]) + $signed({{8{cfg.log_drift[31]}}, cfg.log_drift});
   assign rcp_prod  = mul_p[62:0];
   assign qd_wide   = rcp_prod >> horner_shift(n_ff);
   assign amt_full  = 7'd34 - k_ff;
   assign shifted   = {mul_p[63:0], 4'b0000} >> amt_full;
   assign sum_add   = {1'b0, sum_ff} + {33'd0, pay_ff};
   assign cnt_add   = {1'b0, count_ff} + (mirror_ff ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
   assign price_sum = {2'b00, hi_ff[29:0], 2'b00} + {1'b0, mul_p[62:30]};
   assign price_sat = (|hi_ff[62:30]) || (|price_sum[33:32]);

   always_comb begin
      res.price    = price_sat ? MAX32 : price_sum[31:0];
      res.paths    = PATHS_W'(count_ff);
      res.overflow = ovf_ff || price_sat;
   end

   always_comb begin
      zz_in     = zz_ff;
      side_in   = side_ff;
      mirror_in = mirror_ff;
      last_in   = last_ff;
      x_in      = x_ff;
      k_in      = k_ff;
      t_in      = t_ff;
      e_in      = e_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      pay_in    = pay_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      hi_in     = hi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            zz_in     = {in_item.z[31], in_item.z};
            side_in   = 1'b0;
            mirror_in = in_item.mirror;
            last_in   = in_item.last;
         end
         ST_X_ADD: begin
            priority if (x_sum > EXP_LIMIT) x_in = EXP_LIMIT[33:0];
            else if (x_sum < -EXP_LIMIT)    x_in = -(EXP_LIMIT[33:0]);
            else                            x_in = x_sum[33:0];
         end
         ST_T_MUL: k_in = mul_p[63:57];
         ST_T_CAP: begin
            t_in = mul_p[57:28];
            e_in = ONE_Q30;
            n_in = HORNER_TERMS;
         end
         ST_H_UPD: begin
            e_in = ONE_Q30 + qd_wide[31:0];
            n_in = n_ff - HORNER_N_W'(1);
         end
         ST_S_SHF: s_in = (|shifted[67:32]) ? MAX32 : shifted[31:0];
         ST_PAY:   pay_in = (s_ff > cfg.strike) ? (s_ff - cfg.strike) : 32'd0;
         ST_ACC: begin
            if (sum_add[64]) begin
               sum_in = '1;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_add[63:0];
            end
            if (mirror_ff && !side_ff) begin
               side_in = 1'b1;
               zz_in   = -zz_ff;
            end else if (cnt_add > {1'b0, COUNT_MAX}) begin
               count_in = COUNT_MAX;
               ovf_in   = 1'b1;
            end else begin
               count_in = cnt_add[CNT_W-1:0];
            end
         end
         ST_P_LO: hi_in = mul_p[62:0];
         ST_EMIT: begin
            if (res_ready) begin
               sum_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      zz_ff     <= zz_in;
      side_ff   <= side_in;
      mirror_ff <= mirror_in;
      last_ff   <= last_in;
      x_ff      <= x_in;
      k_ff      <= k_in;
      t_ff      <= t_in;
      e_ff      <= e_in;
      n_ff      <= n_in;
      s_ff      <= s_in;
      pay_ff    <= pay_in;
      hi_ff     <= hi_in;
   end

endmodule

`default_nettype wire
